// ----- sv/obb_overlap_test_macros.svh -----
// assertion macros for the oriented box overlap test block
// the user module must have clk and rst_n in scope
`ifndef OBB_OVERLAP_TEST_MACROS_SVH
`define OBB_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OBB_ASSERT_NOW(lbl, ante, cons, msg)
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/obb_pkg.sv -----
// shared constants and register codes for the oriented box overlap test
// no dependencies
`timescale 1ns / 1ps
package obb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int AXIS_WIDTH_DEF  = 16;

  // apb register file: 64-bit registers at 8-byte spacing
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_SHIFT  = 3;

  typedef enum logic [2:0] {
    REG_A_CENTER_X = 3'd0,
    REG_A_CENTER_Y = 3'd1,
    REG_A_CENTER_Z = 3'd2,
    REG_A_AXIS_U   = 3'd3,
    REG_A_AXIS_V   = 3'd4,
    REG_A_AXIS_W   = 3'd5,
    REG_A_EXTENT_UV = 3'd6,
    REG_A_EXTENT_W = 3'd7
  } cfg_reg_t;

endpackage

// ----- sv/obb_in_if.sv -----
// input channel: one tested box per word, valid/ready handshake
// depends on obb_pkg for default widths
`timescale 1ns / 1ps
interface obb_in_if #(
  parameter int CW = obb_pkg::COORD_WIDTH_DEF,
  parameter int AW = obb_pkg::AXIS_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] b_center_x;
  logic signed [CW-1:0] b_center_y;
  logic signed [CW-1:0] b_center_z;
  logic [3*AW-1:0]      b_axis_u;
  logic [3*AW-1:0]      b_axis_v;
  logic [3*AW-1:0]      b_axis_w;
  logic [CW-1:0]        b_extent_u;
  logic [CW-1:0]        b_extent_v;
  logic [CW-1:0]        b_extent_w;

  modport source (
    output valid, b_center_x, b_center_y, b_center_z, b_axis_u, b_axis_v, b_axis_w,
           b_extent_u, b_extent_v, b_extent_w,
    input  ready
  );
  modport sink (
    input  valid, b_center_x, b_center_y, b_center_z, b_axis_u, b_axis_v, b_axis_w,
           b_extent_u, b_extent_v, b_extent_w,
    output ready
  );
endinterface

// ----- sv/obb_out_if.sv -----
// result channel: one overlap flag per word, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps
interface obb_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

// ----- sv/obb_overlap_test.sv -----
// oriented box overlap test, 15-axis separating axis test, pipelined
// depends on obb_pkg, obb_in_if, obb_out_if and obb_overlap_test_macros.svh
//
//  channel   direction  handshake            word
//  in_ch     in         valid/ready          box b: centre, three axes, extents
//  out_ch    out        valid/ready          overlap flag
//  apb       in         psel/penable/pready  reference box a registers
//
// one box per cycle sustained while the output is taken; a result leaves through
// six arithmetic stages and then the output register
// rst_n is synchronous; it empties the pipeline and clears the box a registers
// each stage holds while it is full and the next one cannot load, so a stalled output only stops
// the stages behind it once they have filled up
`timescale 1ns / 1ps
`include "obb_overlap_test_macros.svh"
module obb_overlap_test #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_WIDTH  = obb_pkg::AXIS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  obb_in_if.sink                         in_ch,
  obb_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [obb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [obb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [obb_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import obb_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = AXIS_WIDTH;
  localparam int F    = AW - 2;         // fraction bits of an axis component
  localparam int DW   = CW + 1;         // centre offset
  localparam int SABW = 2 * AW + 2;     // a.b dot product, signed
  localparam int MABW = 2 * AW + 1;     // its magnitude
  localparam int CCW  = 2 * AW + 1;     // cross product component
  localparam int PDW  = DW + AW;        // offset times axis component
  localparam int SDW  = PDW + 2;        // offset projected on a face axis
  localparam int PFW  = CW + MABW;      // extent times |a.b|
  localparam int FACEW = CW + 2 * AW + 4;
  localparam int PCW  = CCW + AW;       // cross component times axis component
  localparam int MCW  = PCW + 2;        // |c.a| magnitude
  localparam int LO   = (MCW + 1) / 2;  // low slice of |c.a| for the split multiply
  localparam int HI   = MCW - LO;
  localparam int QLW  = CW + LO;
  localparam int QHW  = CW + HI;
  localparam int PDCW = DW + CCW;       // offset times cross component
  localparam int LCW  = PDCW + 2;       // |offset . cross|
  localparam int CROSSW = CW + MCW + 3;
  localparam int NSTG = 6;

  // ---------------------------------------------------------------- apb regs
  logic signed [CW-1:0]   a_center_x_r, a_center_y_r, a_center_z_r;
  logic [3*AW-1:0]        a_axis_u_r, a_axis_v_r, a_axis_w_r;
  logic [APB_DATA_W-1:0]  a_extent_uv_r;
  logic [CW-1:0]          a_extent_w_r;
  cfg_reg_t               reg_idx;

  assign reg_idx = cfg_reg_t'(paddr[APB_ADDR_W-1:REG_SHIFT]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_center_x_r  <= '0;
      a_center_y_r  <= '0;
      a_center_z_r  <= '0;
      a_axis_u_r    <= '0;
      a_axis_v_r    <= '0;
      a_axis_w_r    <= '0;
      a_extent_uv_r <= '0;
      a_extent_w_r  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_A_CENTER_X:  a_center_x_r  <= $signed(pwdata[CW-1:0]);
        REG_A_CENTER_Y:  a_center_y_r  <= $signed(pwdata[CW-1:0]);
        REG_A_CENTER_Z:  a_center_z_r  <= $signed(pwdata[CW-1:0]);
        REG_A_AXIS_U:    a_axis_u_r    <= pwdata[3*AW-1:0];
        REG_A_AXIS_V:    a_axis_v_r    <= pwdata[3*AW-1:0];
        REG_A_AXIS_W:    a_axis_w_r    <= pwdata[3*AW-1:0];
        REG_A_EXTENT_UV: a_extent_uv_r <= pwdata;
        REG_A_EXTENT_W:  a_extent_w_r  <= pwdata[CW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_A_CENTER_X:  prdata = APB_DATA_W'($unsigned(a_center_x_r));
      REG_A_CENTER_Y:  prdata = APB_DATA_W'($unsigned(a_center_y_r));
      REG_A_CENTER_Z:  prdata = APB_DATA_W'($unsigned(a_center_z_r));
      REG_A_AXIS_U:    prdata = APB_DATA_W'(a_axis_u_r);
      REG_A_AXIS_V:    prdata = APB_DATA_W'(a_axis_v_r);
      REG_A_AXIS_W:    prdata = APB_DATA_W'(a_axis_w_r);
      REG_A_EXTENT_UV: prdata = a_extent_uv_r;
      REG_A_EXTENT_W:  prdata = APB_DATA_W'(a_extent_w_r);
    endcase
  end

  // ------------------------------------------------------------ magnitudes
  function automatic logic [SABW-1:0] mag_ab(logic signed [SABW-1:0] x);
    return x[SABW-1] ? $unsigned(-x) : $unsigned(x);
  endfunction
  function automatic logic [SDW-1:0] mag_sd(logic signed [SDW-1:0] x);
    return x[SDW-1] ? $unsigned(-x) : $unsigned(x);
  endfunction
  function automatic logic [MCW-1:0] mag_c(logic signed [MCW-1:0] x);
    return x[MCW-1] ? $unsigned(-x) : $unsigned(x);
  endfunction
  function automatic logic [LCW-1:0] mag_l(logic signed [LCW-1:0] x);
    return x[LCW-1] ? $unsigned(-x) : $unsigned(x);
  endfunction

  // --------------------------------------------------------- flow control
  // a stage loads when it is empty or its successor loads
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;
  logic            out_valid_r;
  logic            out_overlap_r;
  logic            out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_free;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready    = rdy[0];
  assign out_ch.valid   = out_valid_r;
  assign out_ch.overlap = out_overlap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
      if (out_free) out_valid_r <= vld_r[NSTG-1];
    end
  end

  // ------------------------------------------- stage 1: unpack, offset d
  logic [3*AW-1:0]      axa [3];
  logic [3*AW-1:0]      axb [3];
  logic signed [DW-1:0] d_s1_r [3];
  logic signed [AW-1:0] a_s1_r [3][3];
  logic signed [AW-1:0] b_s1_r [3][3];
  logic [CW-1:0]        ea_s1_r [3];
  logic [CW-1:0]        eb_s1_r [3];

  assign axa[0] = a_axis_u_r;
  assign axa[1] = a_axis_v_r;
  assign axa[2] = a_axis_w_r;
  assign axb[0] = in_ch.b_axis_u;
  assign axb[1] = in_ch.b_axis_v;
  assign axb[2] = in_ch.b_axis_w;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d_s1_r[0] <= DW'(a_center_x_r) - DW'(in_ch.b_center_x);
      d_s1_r[1] <= DW'(a_center_y_r) - DW'(in_ch.b_center_y);
      d_s1_r[2] <= DW'(a_center_z_r) - DW'(in_ch.b_center_z);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          a_s1_r[i][k] <= $signed(axa[i][k*AW +: AW]);
          b_s1_r[i][k] <= $signed(axb[i][k*AW +: AW]);
        end
      end
      ea_s1_r[0] <= a_extent_uv_r[CW-1:0];
      ea_s1_r[1] <= a_extent_uv_r[32 +: CW];
      ea_s1_r[2] <= a_extent_w_r;
      eb_s1_r[0] <= in_ch.b_extent_u;
      eb_s1_r[1] <= in_ch.b_extent_v;
      eb_s1_r[2] <= in_ch.b_extent_w;
    end
  end

  // ---------------------- stage 2: |a.b|, cross products, d times axes
  logic [MABW-1:0]       mab_s2_r [3][3];
  logic signed [CCW-1:0] c_s2_r [3][3][3];
  logic signed [PDW-1:0] pda_s2_r [3][3];
  logic signed [PDW-1:0] pdb_s2_r [3][3];
  logic signed [DW-1:0]  d_s2_r [3];
  logic signed [AW-1:0]  a_s2_r [3][3];
  logic signed [AW-1:0]  b_s2_r [3][3];
  logic [CW-1:0]         ea_s2_r [3];
  logic [CW-1:0]         eb_s2_r [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mab_s2_r[i][j] <= MABW'(mag_ab(
            SABW'(a_s1_r[i][0]) * SABW'(b_s1_r[j][0]) +
            SABW'(a_s1_r[i][1]) * SABW'(b_s1_r[j][1]) +
            SABW'(a_s1_r[i][2]) * SABW'(b_s1_r[j][2])));
          c_s2_r[i][j][0] <= CCW'(a_s1_r[i][1]) * CCW'(b_s1_r[j][2]) -
                             CCW'(a_s1_r[i][2]) * CCW'(b_s1_r[j][1]);
          c_s2_r[i][j][1] <= CCW'(a_s1_r[i][2]) * CCW'(b_s1_r[j][0]) -
                             CCW'(a_s1_r[i][0]) * CCW'(b_s1_r[j][2]);
          c_s2_r[i][j][2] <= CCW'(a_s1_r[i][0]) * CCW'(b_s1_r[j][1]) -
                             CCW'(a_s1_r[i][1]) * CCW'(b_s1_r[j][0]);
          pda_s2_r[i][j] <= PDW'(d_s1_r[j]) * PDW'(a_s1_r[i][j]);
          pdb_s2_r[i][j] <= PDW'(d_s1_r[j]) * PDW'(b_s1_r[i][j]);
        end
        d_s2_r[i]  <= d_s1_r[i];
        ea_s2_r[i] <= ea_s1_r[i];
        eb_s2_r[i] <= eb_s1_r[i];
      end
      a_s2_r <= a_s1_r;
      b_s2_r <= b_s1_r;
    end
  end

  // ---------- stage 3: face projections, face radii products, cross terms
  logic [FACEW-1:0]       lwa_s3_r [3];
  logic [FACEW-1:0]       lwb_s3_r [3];
  logic [PFW-1:0]         pfa_s3_r [3][3];
  logic [PFW-1:0]         pfb_s3_r [3][3];
  logic signed [PCW-1:0]  pca_s3_r [3][3][3][3];
  logic signed [PCW-1:0]  pcb_s3_r [3][3][3][3];
  logic signed [PDCW-1:0] pdc_s3_r [3][3][3];
  logic [CW-1:0]          ea_s3_r [3];
  logic [CW-1:0]          eb_s3_r [3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        lwa_s3_r[i] <= FACEW'(mag_sd(SDW'(pda_s2_r[i][0]) + SDW'(pda_s2_r[i][1]) +
                                     SDW'(pda_s2_r[i][2]))) << F;
        lwb_s3_r[i] <= FACEW'(mag_sd(SDW'(pdb_s2_r[i][0]) + SDW'(pdb_s2_r[i][1]) +
                                     SDW'(pdb_s2_r[i][2]))) << F;
        for (int j = 0; j < 3; j++) begin
          pfa_s3_r[i][j] <= PFW'(eb_s2_r[j]) * PFW'(mab_s2_r[i][j]);
          pfb_s3_r[j][i] <= PFW'(ea_s2_r[i]) * PFW'(mab_s2_r[i][j]);
          for (int m = 0; m < 3; m++) begin
            pdc_s3_r[i][j][m] <= PDCW'(d_s2_r[m]) * PDCW'(c_s2_r[i][j][m]);
            for (int k = 0; k < 3; k++) begin
              pca_s3_r[i][j][k][m] <= PCW'(c_s2_r[i][j][m]) * PCW'(a_s2_r[k][m]);
              pcb_s3_r[i][j][k][m] <= PCW'(c_s2_r[i][j][m]) * PCW'(b_s2_r[k][m]);
            end
          end
        end
        ea_s3_r[i] <= ea_s2_r[i];
        eb_s3_r[i] <= eb_s2_r[i];
      end
    end
  end

  // ------------- stage 4: face axis verdicts, |c.a|, |c.b|, |d.c|
  logic [5:0]       sepf_nxt;
  logic [5:0]       sepf_s4_r;
  logic [MCW-1:0]   mca_s4_r [3][3][3];
  logic [MCW-1:0]   mcb_s4_r [3][3][3];
  logic [LCW-1:0]   lwc_s4_r [3][3];
  logic [CW-1:0]    ea_s4_r [3];
  logic [CW-1:0]    eb_s4_r [3];

  // face of a: own radius is its extent, b radius from |a.b|; likewise face of b
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sepf_nxt[i] = lwa_s3_r[i] > ((FACEW'(ea_s3_r[i]) << (2 * F)) +
                    FACEW'(pfa_s3_r[i][0]) + FACEW'(pfa_s3_r[i][1]) +
                    FACEW'(pfa_s3_r[i][2]));
      sepf_nxt[3+i] = lwb_s3_r[i] > ((FACEW'(eb_s3_r[i]) << (2 * F)) +
                      FACEW'(pfb_s3_r[i][0]) + FACEW'(pfb_s3_r[i][1]) +
                      FACEW'(pfb_s3_r[i][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sepf_s4_r <= sepf_nxt;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lwc_s4_r[i][j] <= mag_l(LCW'(pdc_s3_r[i][j][0]) + LCW'(pdc_s3_r[i][j][1]) +
                                  LCW'(pdc_s3_r[i][j][2]));
          for (int k = 0; k < 3; k++) begin
            mca_s4_r[i][j][k] <= mag_c(MCW'(pca_s3_r[i][j][k][0]) +
                                       MCW'(pca_s3_r[i][j][k][1]) +
                                       MCW'(pca_s3_r[i][j][k][2]));
            mcb_s4_r[i][j][k] <= mag_c(MCW'(pcb_s3_r[i][j][k][0]) +
                                       MCW'(pcb_s3_r[i][j][k][1]) +
                                       MCW'(pcb_s3_r[i][j][k][2]));
          end
        end
        ea_s4_r[i] <= ea_s3_r[i];
        eb_s4_r[i] <= eb_s3_r[i];
      end
    end
  end

  // ------ stage 5: extent times |c.axis|, split in two narrower multiplies
  logic [QLW-1:0]    qalo_s5_r [3][3][3];
  logic [QHW-1:0]    qahi_s5_r [3][3][3];
  logic [QLW-1:0]    qblo_s5_r [3][3][3];
  logic [QHW-1:0]    qbhi_s5_r [3][3][3];
  logic [CROSSW-1:0] lwc_s5_r [3][3];
  logic [5:0]        sepf_s5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sepf_s5_r <= sepf_s4_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lwc_s5_r[i][j] <= CROSSW'(lwc_s4_r[i][j]) << F;
          for (int k = 0; k < 3; k++) begin
            qalo_s5_r[i][j][k] <= QLW'(ea_s4_r[k]) * QLW'(mca_s4_r[i][j][k][LO-1:0]);
            qahi_s5_r[i][j][k] <= QHW'(ea_s4_r[k]) * QHW'(mca_s4_r[i][j][k][MCW-1:LO]);
            qblo_s5_r[i][j][k] <= QLW'(eb_s4_r[k]) * QLW'(mcb_s4_r[i][j][k][LO-1:0]);
            qbhi_s5_r[i][j][k] <= QHW'(eb_s4_r[k]) * QHW'(mcb_s4_r[i][j][k][MCW-1:LO]);
          end
        end
      end
    end
  end

  // ---------------------- stage 6: cross axis radii of both boxes
  // the axis a_i x b_j is normal to a_i and b_j, so those terms drop out
  logic [CROSSW-1:0] rac_nxt [3][3];
  logic [CROSSW-1:0] rbc_nxt [3][3];
  logic [CROSSW-1:0] rac_s6_r [3][3];
  logic [CROSSW-1:0] rbc_s6_r [3][3];
  logic [CROSSW-1:0] lwc_s6_r [3][3];
  logic [5:0]        sepf_s6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rac_nxt[i][j] = '0;
        rbc_nxt[i][j] = '0;
        for (int k = 0; k < 3; k++) begin
          if (k != i) begin
            rac_nxt[i][j] = rac_nxt[i][j] + CROSSW'(qalo_s5_r[i][j][k]) +
                            (CROSSW'(qahi_s5_r[i][j][k]) << LO);
          end
          if (k != j) begin
            rbc_nxt[i][j] = rbc_nxt[i][j] + CROSSW'(qblo_s5_r[i][j][k]) +
                            (CROSSW'(qbhi_s5_r[i][j][k]) << LO);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sepf_s6_r <= sepf_s5_r;
      rac_s6_r  <= rac_nxt;
      rbc_s6_r  <= rbc_nxt;
      lwc_s6_r  <= lwc_s5_r;
    end
  end

  // ------------------------------------ output register: final verdict
  // touching (equal) never separates; a zero cross axis gives 0 > 0
  logic overlap_nxt;

  always_comb begin
    overlap_nxt = !(|sepf_s6_r);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (lwc_s6_r[i][j] > rac_s6_r[i][j] + rbc_s6_r[i][j]) overlap_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) out_overlap_r <= overlap_nxt;
  end

  // ---------------------------------------------------------- assertions
  `OBB_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0], "accepted box lost at entry")
  `OBB_ASSERT_NEXT(a_last_holds, vld_r[NSTG-1] && out_valid_r && !out_ch.ready, vld_r[NSTG-1], "last stage dropped while output stalled")
  `OBB_ASSERT_NEXT(a_face_sep, vld_r[NSTG-1] && out_free && (|sepf_s6_r), out_valid_r && !out_overlap_r, "face separation not reported")
  `OBB_ASSERT_NOW(a_out_from_pipe, $rose(out_valid_r), $past(vld_r[NSTG-1]), "result without a box in the last stage")

endmodule

// ----- tb/sv/tb_obb_overlap_test.sv -----
// testbench for obb_overlap_test: streams tested boxes against reference box settings
// depends on obb_pkg, obb_in_if, obb_out_if and the obb_overlap_test rtl
`timescale 1ns / 1ps
module tb_obb_overlap_test;
  import obb_pkg::*;

  localparam int          LIMIT_CYCLES = 5000;  // cycles with no word or register write moved
  localparam int          DRAIN_CYCLES = 12;    // pipeline latency plus margin
  localparam int          BY_MODEL = 2;         // row result comes from the predictor
  localparam logic [15:0] ONE  = 16'h4000;      // 1.0 in q1.14
  localparam logic [15:0] MONE = 16'hC000;      // -1.0
  localparam logic [15:0] DIAG = 16'h2D41;      // about 0.7071

  typedef struct {
    logic [31:0] center[3];
    logic [47:0] axis[3];
    logic [31:0] extent[3];
  } box_t;

  typedef struct {
    int   phase;
    box_t box;
    int   want;  // 0 or 1 typed in, or BY_MODEL
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  obb_in_if  in_ch ();
  obb_out_if out_ch ();

  obb_overlap_test i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the reference box registers
  logic [31:0] ref_center[3];
  logic [47:0] ref_axis[3];
  logic [63:0] ref_extent_uv;
  logic [31:0] ref_extent_w;

  bit   overlap_q[$];   // expected overlap flags, oldest first
  int   mismatches = 0;
  bit   no_gaps = 1'b0; // long stretch with neither side idling
  int   quiet_cycles = 0;
  bit   moved;

  stim_row_t rows[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.b_center_x = '0; in_ch.b_center_y = '0; in_ch.b_center_z = '0;
    in_ch.b_axis_u = '0; in_ch.b_axis_v = '0; in_ch.b_axis_w = '0;
    in_ch.b_extent_u = '0; in_ch.b_extent_v = '0; in_ch.b_extent_w = '0;
    out_ch.ready = 1'b0;
    foreach (ref_center[k]) begin
      ref_center[k] = '0;
      ref_axis[k] = '0;
    end
    ref_extent_uv = '0;
    ref_extent_w = '0;
  end

  function automatic logic [47:0] pk(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [127:0] mag(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint dot(longint x[3], longint y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // separating axis test at exact fixed-point scale, 1 means the boxes overlap
  function automatic bit boxes_overlap(box_t b);
    longint d[3], a[3][3], bx[3][3], c[3], ea[3], eb[3];
    logic [127:0] lhs, ra, rb;
    logic signed [127:0] proj;
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'($signed(ref_center[k])) - longint'($signed(b.center[k]));
      for (int m = 0; m < 3; m++) begin
        a[k][m]  = longint'($signed(ref_axis[k][16*m +: 16]));
        bx[k][m] = longint'($signed(b.axis[k][16*m +: 16]));
      end
      eb[k] = longint'(b.extent[k]);
    end
    ea[0] = longint'(ref_extent_uv[31:0]);
    ea[1] = longint'(ref_extent_uv[63:32]);
    ea[2] = longint'(ref_extent_w);
    // face axes of a
    for (int i = 0; i < 3; i++) begin
      lhs = mag(dot(d, a[i])) << 14;
      ra = 128'(ea[i]) << 28;
      rb = '0;
      for (int j = 0; j < 3; j++) rb += 128'(eb[j]) * mag(dot(a[i], bx[j]));
      if (lhs > ra + rb) return 1'b0;
    end
    // face axes of b
    for (int j = 0; j < 3; j++) begin
      lhs = mag(dot(d, bx[j])) << 14;
      rb = 128'(eb[j]) << 28;
      ra = '0;
      for (int i = 0; i < 3; i++) ra += 128'(ea[i]) * mag(dot(bx[j], a[i]));
      if (lhs > ra + rb) return 1'b0;
    end
    // cross axes, a zero cross product never separates
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c[0] = a[i][1] * bx[j][2] - a[i][2] * bx[j][1];
        c[1] = a[i][2] * bx[j][0] - a[i][0] * bx[j][2];
        c[2] = a[i][0] * bx[j][1] - a[i][1] * bx[j][0];
        proj = 128'(d[0]) * 128'(c[0]) + 128'(d[1]) * 128'(c[1])
             + 128'(d[2]) * 128'(c[2]);
        lhs = ((proj < 0) ? -proj : proj) << 14;
        ra = '0;
        rb = '0;
        for (int k = 0; k < 3; k++) begin
          if (k != i) ra += 128'(ea[k]) * mag(dot(c, a[k]));
          if (k != j) rb += 128'(eb[k]) * mag(dot(c, bx[k]));
        end
        if (lhs > ra + rb) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic box_t mk_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                  logic [47:0] au, logic [47:0] av, logic [47:0] aw,
                                  logic [31:0] eu, logic [31:0] ev, logic [31:0] ew);
    box_t b;
    b.center = '{cx, cy, cz};
    b.axis   = '{au, av, aw};
    b.extent = '{eu, ev, ew};
    return b;
  endfunction

  function automatic logic [47:0] rand_axis48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // tidy boxes sit near the origin with unit-ish axes so both outcomes show up
  function automatic box_t rand_box(bit tidy);
    box_t b;
    int   p;
    logic [15:0] s[3];
    for (int k = 0; k < 3; k++) begin
      if (tidy) begin
        b.center[k] = 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
        b.extent[k] = 32'($urandom_range(1 << 12, 3 << 16));
      end else begin
        b.center[k] = $urandom;
        b.extent[k] = $urandom;
      end
    end
    if (!tidy) begin
      foreach (b.axis[k]) b.axis[k] = rand_axis48();
    end else if ($urandom_range(1)) begin
      // signed permutation of the unit axes
      p = $urandom_range(2);
      for (int k = 0; k < 3; k++) begin
        s = '{16'h0, 16'h0, 16'h0};
        s[(k + p) % 3] = $urandom_range(1) ? ONE : MONE;
        b.axis[k] = pk(s[0], s[1], s[2]);
      end
    end else begin
      foreach (b.axis[k])
        b.axis[k] = pk(16'($urandom_range(0, 32768)) - 16'h4000,
                       16'($urandom_range(0, 32768)) - 16'h4000,
                       16'($urandom_range(0, 32768)) - 16'h4000);
    end
    return b;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_SHIFT;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_A_CENTER_X:  ref_center[0] = val[31:0];
      REG_A_CENTER_Y:  ref_center[1] = val[31:0];
      REG_A_CENTER_Z:  ref_center[2] = val[31:0];
      REG_A_AXIS_U:    ref_axis[0] = val[47:0];
      REG_A_AXIS_V:    ref_axis[1] = val[47:0];
      REG_A_AXIS_W:    ref_axis[2] = val[47:0];
      REG_A_EXTENT_UV: ref_extent_uv = val;
      REG_A_EXTENT_W:  ref_extent_w = val[31:0];
      default: ;
    endcase
  endtask

  // reprogram box a, only once the pipeline has drained
  task automatic set_ref(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                         logic [47:0] au, logic [47:0] av, logic [47:0] aw,
                         logic [63:0] euv, logic [31:0] ew);
    in_ch.valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_A_CENTER_X, 64'(cx));
    write_reg(REG_A_CENTER_Y, 64'(cy));
    write_reg(REG_A_CENTER_Z, 64'(cz));
    write_reg(REG_A_AXIS_U, 64'(au));
    write_reg(REG_A_AXIS_V, 64'(av));
    write_reg(REG_A_AXIS_W, 64'(aw));
    write_reg(REG_A_EXTENT_UV, euv);
    write_reg(REG_A_EXTENT_W, 64'(ew));
  endtask

  task automatic set_ref_phase(int ph);
    case (ph)
      // identity box of half size one at the origin
      1: set_ref(0, 0, 0, pk(ONE, 0, 0), pk(0, ONE, 0), pk(0, 0, ONE),
                 {32'h10000, 32'h10000}, 32'h10000);
      // every register all ones, but the x and z centres at the signed maximum
      2: set_ref(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, '1, '1, '1, '1, '1);
      // most negative centres, axis components at both extremes
      3: set_ref(32'h80000000, 32'h80000000, 32'h80000000,
                 pk(16'h8000, 16'h8000, 16'h8000), pk(16'h8000, 0, 16'h7FFF),
                 pk(16'h7FFF, 16'h7FFF, 16'h7FFF), 64'h1, 32'h0);
      // rotated box near the origin
      4: set_ref(32'h8000, 32'hFFFF8000, 32'h0, pk(DIAG, DIAG, 0),
                 pk(16'hD2BF, DIAG, 0), pk(0, 0, ONE),
                 {32'h18000, 32'h8000}, 32'h20000);
      // random everything
      5: set_ref($urandom, $urandom, $urandom, rand_axis48(), rand_axis48(),
                 rand_axis48(), {$urandom, $urandom}, $urandom);
      default: ;
    endcase
  endtask

  task automatic send_box(box_t b, int want);
    while (!no_gaps && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.b_center_x <= b.center[0];
    in_ch.b_center_y <= b.center[1];
    in_ch.b_center_z <= b.center[2];
    in_ch.b_axis_u   <= b.axis[0];
    in_ch.b_axis_v   <= b.axis[1];
    in_ch.b_axis_w   <= b.axis[2];
    in_ch.b_extent_u <= b.extent[0];
    in_ch.b_extent_v <= b.extent[1];
    in_ch.b_extent_w <= b.extent[2];
    do @(posedge clk); while (!in_ch.ready);
    overlap_q.push_back(want == BY_MODEL ? boxes_overlap(b) : bit'(want));
  endtask

  task automatic flag_mismatch(string what, bit exp_v, bit got_v);
    if (mismatches < 10)
      $display("%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  // result side: random stalls and the scoreboard
  always @(posedge clk) begin
    bit exp_v;
    out_ch.ready <= no_gaps || ($urandom_range(99) >= 6);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (overlap_q.size() == 0) begin
        flag_mismatch("unexpected word, overlap", 1'b0, out_ch.overlap);
      end else begin
        exp_v = overlap_q.pop_front();
        if (out_ch.overlap !== exp_v) flag_mismatch("overlap", exp_v, out_ch.overlap);
      end
    end
  end

  // watchdog on cycles in which no word or register write moves
  always @(posedge clk) begin
    moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
         || (psel && penable);
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    if (rst_n && quiet_cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int ph;
    // directed rows, typed-in results only where obvious
    rows.push_back('{0, mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0), 1});            // all zero, touching
    rows.push_back('{0, mk_box(32'h640000, 0, 0, pk(ONE, 0, 0), 0, 0, 0, 0, 0), 0});
    rows.push_back('{0, mk_box(32'h7FFFFFFF, 32'h80000000, 0, '1, '1, '1,
                               '1, '1, '1), BY_MODEL});
    rows.push_back('{1, mk_box(32'h20000, 0, 0, pk(ONE, 0, 0), pk(0, ONE, 0),
                               pk(0, 0, ONE), 32'h10000, 32'h10000, 32'h10000), 1});
    rows.push_back('{1, mk_box(32'h20001, 0, 0, pk(ONE, 0, 0), pk(0, ONE, 0),
                               pk(0, 0, ONE), 32'h10000, 32'h10000, 32'h10000), 0});
    rows.push_back('{1, mk_box(32'h24000, 32'h8000, 0, pk(DIAG, DIAG, 0),
                               pk(16'hD2BF, DIAG, 0), pk(0, 0, ONE),
                               32'h10000, 32'h8000, 32'h10000), BY_MODEL});
    rows.push_back('{1, mk_box(32'hFFFD0000, 32'h10000, 32'h8000,
                               pk(16'h7FFF, 0, 16'h8000), pk(0, 16'h7FFF, 0),
                               pk(16'h8000, 16'h8000, 16'h7FFF),
                               32'h100, 32'h4000, 32'h20000), BY_MODEL});
    rows.push_back('{1, mk_box(32'h80000000, 32'h80000000, 32'h80000000,
                               pk(ONE, 0, 0), pk(0, ONE, 0), pk(0, 0, ONE),
                               '1, '1, '1), BY_MODEL});
    rows.push_back('{1, mk_box(32'h30000, 32'h30000, 0, pk(0, DIAG, DIAG),
                               pk(DIAG, 0, DIAG), pk(DIAG, DIAG, 0),
                               32'h18000, 32'h18000, 32'h18000), BY_MODEL});
    rows.push_back('{2, mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0), BY_MODEL});
    rows.push_back('{2, mk_box(32'h80000000, 32'h80000000, 32'h80000000,
                               pk(16'h8000, 16'h8000, 16'h8000),
                               pk(16'h8000, 16'h8000, 16'h8000),
                               pk(16'h8000, 16'h8000, 16'h8000), 0, 0, 0), BY_MODEL});
    rows.push_back('{2, mk_box(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '1, '1, '1,
                               '1, '1, '1), BY_MODEL});
    rows.push_back('{3, mk_box(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               pk(16'h7FFF, 16'h7FFF, 16'h7FFF), pk(16'h8000, 0, 0),
                               pk(0, 0, 16'h8000), 32'hFFFFFFFF, 0, 32'h1), BY_MODEL});
    rows.push_back('{3, mk_box(32'h80000000, 32'h80000000, 32'h80000000,
                               pk(16'h8000, 16'h8000, 16'h8000), 0, 0, 0, 0, 0), BY_MODEL});
    rows.push_back('{4, mk_box(0, 0, 0, pk(ONE, 0, 0), pk(0, ONE, 0),
                               pk(0, 0, ONE), 32'h8000, 32'h8000, 32'h8000), BY_MODEL});
    rows.push_back('{4, mk_box(32'h38000, 32'hFFFC8000, 0, pk(DIAG, DIAG, 0),
                               pk(16'hD2BF, DIAG, 0), pk(0, 0, ONE),
                               32'h10000, 32'h10000, 32'h10000), BY_MODEL});

    // synchronous reset, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ph = 0;
    foreach (rows[r]) begin
      if (rows[r].phase != ph) begin
        ph = rows[r].phase;
        set_ref_phase(ph);
      end
      send_box(rows[r].box, rows[r].want);
    end

    // random part, mostly tidy boxes, settings changed between blocks
    for (int blk = 0; blk < 8; blk++) begin
      set_ref_phase(blk == 7 ? 2 : (blk % 3 == 2) ? 5 : (blk % 2 == 0) ? 1 : 4);
      no_gaps = (blk == 3);
      for (int n = 0; n < 205; n++)
        send_box(rand_box($urandom_range(99) < 85), BY_MODEL);
    end
    no_gaps = 1'b0;
    in_ch.valid <= 1'b0;

    while (overlap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && overlap_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
